// ===== rtl/pan_tilt_deadband_servo_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pan/tilt servo tracker
// Clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef PAN_TILT_DEADBAND_SERVO_TRACKER_MACROS_SVH
`define PAN_TILT_DEADBAND_SERVO_TRACKER_MACROS_SVH

// plain property check
`define PTDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ptds assertion failed");

// same-cycle implication check
`define PTDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptds implication failed");

`endif

// ===== rtl/ptds_pkg.sv =====
// ----------------------------------------------------------------------------
// ptds_pkg
// Shared widths, codes and arithmetic helpers for the servo tracker
// ----------------------------------------------------------------------------
package ptds_pkg;

  // field and state widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned DB_W    = 8;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned PULSE_W = 6;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned HIGH_W  = 12;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // parameter defaults
  localparam int unsigned PERIOD_US_DEF   = 20000;
  localparam int unsigned FULL_SWEEP_DEF  = 40;

  // angle limits
  localparam logic [ANGLE_W-1:0] ANGLE_MAX    = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] ANGLE_CENTER = ANGLE_W'(90);

  // config reset values
  localparam logic [COORD_W-1:0] CENTER_X_RST = COORD_W'(640);
  localparam logic [COORD_W-1:0] CENTER_Y_RST = COORD_W'(360);
  localparam logic [DB_W-1:0]    DEADBAND_RST = DB_W'(20);
  localparam logic [STEP_W-1:0]  STEP_RST     = STEP_W'(3);

  // queue depth between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALIGN   = 2'd2;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_DEADBAND = 2'd2,
    CFG_STEP     = 2'd3
  } cfg_idx_e;

  // classified operation
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_OBSERVE = 2'd1,
    OP_ALIGN   = 2'd2
  } op_e;

  typedef struct packed {
    op_e  op;
    logic pan_up;
    logic pan_dn;
    logic tilt_up;
    logic tilt_dn;
  } op_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  item;
  } q_head_t;

  // floor(10.3 * a + 546) = 10a + 546 + floor(3a / 10), 3a/10 via a*615 >> 11
  function automatic logic [HIGH_W-1:0] high_time_for(input logic [ANGLE_W-1:0] a);
    logic [17:0]       frac;
    logic [HIGH_W-1:0] base;
    frac = 18'(a) * 18'd615;
    base = HIGH_W'(a) * HIGH_W'(10) + HIGH_W'(546);
    return base + HIGH_W'(frac >> 11);
  endfunction

  // ceil(2d / 9) = floor((2d + 8) / 9), divide via x*57 >> 9 for x below 135
  function automatic logic [PULSE_W-1:0] pulses_for(input logic [STEP_W-1:0] d);
    logic [7:0]  x;
    logic [13:0] prod;
    x    = {1'b0, d, 1'b0} + 8'd8;
    prod = 14'(x) * 14'd57;
    return PULSE_W'(prod >> 9);
  endfunction

endpackage

// ===== rtl/ptds_front.sv =====
// ----------------------------------------------------------------------------
// ptds_front
// Accepts input items, decodes kind and does the deadband compares
// ----------------------------------------------------------------------------
module ptds_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptds_pkg::KIND_W-1:0]   kind_i,
  input  logic [ptds_pkg::COORD_W-1:0]  face_x_i,
  input  logic [ptds_pkg::COORD_W-1:0]  face_y_i,
  input  logic [ptds_pkg::COORD_W-1:0]  center_x_i,
  input  logic [ptds_pkg::COORD_W-1:0]  center_y_i,
  input  logic [ptds_pkg::DB_W-1:0]     deadband_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output ptds_pkg::op_t                 push_item_o
);
  import ptds_pkg::*;

  localparam int unsigned SUM_W = COORD_W + 1;

  logic [SUM_W-1:0] fx_ext, fy_ext, cx_ext, cy_ext, db_ext;

  // handshake toward the queue
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign fx_ext = SUM_W'(face_x_i);
  assign fy_ext = SUM_W'(face_y_i);
  assign cx_ext = SUM_W'(center_x_i);
  assign cy_ext = SUM_W'(center_y_i);
  assign db_ext = SUM_W'(deadband_i);

  // kind decode and deadband compares per axis, unused code runs as a tick
  always_comb begin
    push_item_o.pan_up  = fx_ext > (cx_ext + db_ext);
    push_item_o.pan_dn  = (fx_ext + db_ext) < cx_ext;
    push_item_o.tilt_up = fy_ext > (cy_ext + db_ext);
    push_item_o.tilt_dn = (fy_ext + db_ext) < cy_ext;
    unique case (kind_i)
      KIND_OBSERVE: push_item_o.op = OP_OBSERVE;
      KIND_ALIGN:   push_item_o.op = OP_ALIGN;
      default:      push_item_o.op = OP_TICK;
    endcase
  end

endmodule

// ===== rtl/ptds_queue.sv =====
// ----------------------------------------------------------------------------
// ptds_queue
// Short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module ptds_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ptds_pkg::op_t    push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output ptds_pkg::q_head_t head_o
);
  import ptds_pkg::*;

  op_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_pop;

  assign full_o      = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/ptds_back.sv =====
// ----------------------------------------------------------------------------
// ptds_back
// Executes queued items: angle moves, pulse trains and the result register
// ----------------------------------------------------------------------------
module ptds_back #(
  parameter int unsigned PERIOD_US         = ptds_pkg::PERIOD_US_DEF,
  parameter int unsigned FULL_SWEEP_PULSES = ptds_pkg::FULL_SWEEP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptds_pkg::q_head_t             head_i,
  output logic                          pop_o,
  input  logic [ptds_pkg::STEP_W-1:0]   step_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pan_pin_o,
  output logic                          tilt_pin_o,
  output logic                          busy_res_o,
  output logic                          dropped_o,
  output logic [ptds_pkg::ANGLE_W-1:0]  pan_now_o,
  output logic [ptds_pkg::ANGLE_W-1:0]  tilt_now_o
);
  import ptds_pkg::*;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [PULSE_W-1:0] pulses;
  } move_t;

  // one axis step with clamp and pulse count for the actual change
  function automatic move_t move_axis(input logic [ANGLE_W-1:0] a,
                                      input logic up, input logic dn,
                                      input logic [STEP_W-1:0] step);
    move_t            r;
    logic [ANGLE_W:0] sum;
    logic [ANGLE_W-1:0] d;
    sum = {1'b0, a} + (ANGLE_W + 1)'(step);
    r.angle  = a;
    r.pulses = '0;
    d        = '0;
    if (up) begin
      r.angle = (sum > (ANGLE_W + 1)'(ANGLE_MAX)) ? ANGLE_MAX : sum[ANGLE_W-1:0];
      d       = r.angle - a;
      r.pulses = pulses_for(d[STEP_W-1:0]);
    end else if (dn) begin
      r.angle = (a < ANGLE_W'(step)) ? '0 : a - ANGLE_W'(step);
      d       = a - r.angle;
      r.pulses = pulses_for(d[STEP_W-1:0]);
    end
    return r;
  endfunction

  // tracker state
  logic [ANGLE_W-1:0] pan_q, pan_d, tilt_q, tilt_d;
  logic [PULSE_W-1:0] pan_left_q, pan_left_d, tilt_left_q, tilt_left_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [HIGH_W-1:0]  high_q, high_d;
  logic               axis_q, axis_d;

  // result register
  logic               out_valid_q;
  logic               pan_pin_q, pan_pin_d, tilt_pin_q, tilt_pin_d;
  logic               busy_q, drop_q, drop_d;
  logic [ANGLE_W-1:0] pan_now_q, tilt_now_q;

  logic               fire, busy;
  logic               level;
  logic [CNT_W-1:0]   cnt_inc;
  move_t              pan_mv, tilt_mv;
  logic [HIGH_W-1:0]  high_pan_mv, high_tilt_mv, high_tilt_now;
  logic [PULSE_W-1:0] pan_dec;

  assign fire  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;
  assign busy  = (pan_left_q != '0) || (tilt_left_q != '0);

  assign pan_mv  = move_axis(pan_q, head_i.item.pan_up, head_i.item.pan_dn, step_i);
  assign tilt_mv = move_axis(tilt_q, head_i.item.tilt_up, head_i.item.tilt_dn, step_i);
  assign high_pan_mv   = high_time_for(pan_mv.angle);
  assign high_tilt_mv  = high_time_for(tilt_mv.angle);
  assign high_tilt_now = high_time_for(tilt_q);

  assign level   = {1'b0, cnt_q} < (CNT_W + 1)'(high_q);
  assign cnt_inc = cnt_q + 1'b1;
  assign pan_dec = (pan_left_q != '0) ? pan_left_q - 1'b1 : '0;

  // execute one item
  always_comb begin
    pan_d       = pan_q;
    tilt_d      = tilt_q;
    pan_left_d  = pan_left_q;
    tilt_left_d = tilt_left_q;
    cnt_d       = cnt_q;
    high_d      = high_q;
    axis_d      = axis_q;
    pan_pin_d   = 1'b0;
    tilt_pin_d  = 1'b0;
    drop_d      = 1'b0;
    unique case (head_i.item.op)
      OP_OBSERVE: begin
        if (busy) begin
          drop_d = 1'b1;
        end else begin
          pan_d       = pan_mv.angle;
          tilt_d      = tilt_mv.angle;
          pan_left_d  = pan_mv.pulses;
          tilt_left_d = tilt_mv.pulses;
          cnt_d       = '0;
          if (pan_mv.pulses != '0) begin
            axis_d = 1'b0;
            high_d = high_pan_mv;
          end else if (tilt_mv.pulses != '0) begin
            axis_d = 1'b1;
            high_d = high_tilt_mv;
          end
        end
      end
      OP_ALIGN: begin
        if (busy) begin
          drop_d = 1'b1;
        end else begin
          pan_d       = ANGLE_CENTER;
          tilt_d      = ANGLE_CENTER;
          pan_left_d  = PULSE_W'(FULL_SWEEP_PULSES);
          tilt_left_d = PULSE_W'(FULL_SWEEP_PULSES);
          cnt_d       = '0;
          axis_d      = 1'b0;
          high_d      = high_time_for(ANGLE_CENTER);
        end
      end
      default: begin
        if (busy) begin
          pan_pin_d  = !axis_q && level;
          tilt_pin_d = axis_q && level;
          cnt_d      = cnt_inc;
          // end of one servo period
          if (cnt_inc >= CNT_W'(PERIOD_US)) begin
            cnt_d = '0;
            if (!axis_q) begin
              pan_left_d = pan_dec;
              if (pan_dec == '0 && tilt_left_q != '0) begin
                axis_d = 1'b1;
                high_d = high_tilt_now;
              end
            end else if (tilt_left_q != '0) begin
              tilt_left_d = tilt_left_q - 1'b1;
            end
          end
        end
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q       <= ANGLE_CENTER;
      tilt_q      <= ANGLE_CENTER;
      pan_left_q  <= '0;
      tilt_left_q <= '0;
      cnt_q       <= '0;
      high_q      <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        pan_q       <= pan_d;
        tilt_q      <= tilt_d;
        pan_left_q  <= pan_left_d;
        tilt_left_q <= tilt_left_d;
        cnt_q       <= cnt_d;
        high_q      <= high_d;
        axis_q      <= axis_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pan_pin_q  <= pan_pin_d;
      tilt_pin_q <= tilt_pin_d;
      busy_q     <= (pan_left_d != '0) || (tilt_left_d != '0);
      drop_q     <= drop_d;
      pan_now_q  <= pan_d;
      tilt_now_q <= tilt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pan_pin_o   = pan_pin_q;
  assign tilt_pin_o  = tilt_pin_q;
  assign busy_res_o  = busy_q;
  assign dropped_o   = drop_q;
  assign pan_now_o   = pan_now_q;
  assign tilt_now_o  = tilt_now_q;

endmodule

// ===== rtl/pan_tilt_deadband_servo_tracker.sv =====
// A result passes through the queue and then the back-end result register after its item is accepted.
// Throughput: one item per cycle, ticks included, while the output is not stalled.
// The two-entry queue keeps the input open while the output is stalled, until the queue is full.
// Reset: angles 90, no pulses queued, counter 0, frame centre 640/360, deadband 20, step 3.
// ----------------------------------------------------------------------------
// pan_tilt_deadband_servo_tracker
// Deadband pan/tilt tracker driving two servo pins from microsecond ticks
// ----------------------------------------------------------------------------
module pan_tilt_deadband_servo_tracker #(
  parameter int unsigned PERIOD_US         = ptds_pkg::PERIOD_US_DEF,
  parameter int unsigned FULL_SWEEP_PULSES = ptds_pkg::FULL_SWEEP_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            cfg_we_i,
  input  logic [ptds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptds_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ptds_pkg::KIND_W-1:0]     kind_i,
  input  logic [ptds_pkg::COORD_W-1:0]    face_x_i,
  input  logic [ptds_pkg::COORD_W-1:0]    face_y_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            pan_pin_o,
  output logic                            tilt_pin_o,
  output logic                            busy_res_o,
  output logic                            dropped_o,
  output logic [ptds_pkg::ANGLE_W-1:0]    pan_now_o,
  output logic [ptds_pkg::ANGLE_W-1:0]    tilt_now_o
);
  import ptds_pkg::*;

  `include "pan_tilt_deadband_servo_tracker_macros.svh"

  logic [COORD_W-1:0] center_x_q, center_y_q;
  logic [DB_W-1:0]    deadband_q;
  logic [STEP_W-1:0]  step_q;

  logic    q_full, push, pop;
  op_t     push_item;
  q_head_t head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      deadband_q <= DEADBAND_RST;
      step_q     <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X: center_x_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_CENTER_Y: center_y_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_DEADBAND: deadband_q <= cfg_wdata_i[DB_W-1:0];
        CFG_STEP:     step_q     <= cfg_wdata_i[STEP_W-1:0];
        default:      ;
      endcase
    end
  end

  // front end: accept and classify
  ptds_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .face_x_i    (face_x_i),
    .face_y_i    (face_y_i),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .deadband_i  (deadband_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // queue between the halves
  ptds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  // back end: execute and hold the result
  ptds_back #(
    .PERIOD_US         (PERIOD_US),
    .FULL_SWEEP_PULSES (FULL_SWEEP_PULSES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .step_i      (step_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pan_pin_o   (pan_pin_o),
    .tilt_pin_o  (tilt_pin_o),
    .busy_res_o  (busy_res_o),
    .dropped_o   (dropped_o),
    .pan_now_o   (pan_now_o),
    .tilt_now_o  (tilt_now_o)
  );

  // checks
  `PTDS_ASSERT_IMP(a_pins_exclusive, out_valid_o, !(pan_pin_o && tilt_pin_o))
  `PTDS_ASSERT_IMP(a_drop_no_pins, out_valid_o && dropped_o, !pan_pin_o && !tilt_pin_o)
  `PTDS_ASSERT_IMP(a_drop_when_busy, out_valid_o && dropped_o, busy_res_o)
  `PTDS_ASSERT_IMP(a_angle_range, out_valid_o, pan_now_o <= ANGLE_MAX && tilt_now_o <= ANGLE_MAX)

endmodule

// ===== test/pan_tilt_deadband_servo_tracker_test.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_deadband_servo_tracker_test
// Self-checking bench for the pan/tilt servo tracker. A cycle-exact tracker
// model predicts one result per accepted item (pins, busy, drop, angles).
// Directed tests hit idle ticks, deadband edges, zero step, a move just past
// the deadband, busy drops and the fall of the pan pin; random traffic runs
// under three idle/stall mixes, first while idle, then during a pulse train.
// ----------------------------------------------------------------------------
module pan_tilt_deadband_servo_tracker_test;
  import ptds_pkg::*;

  // servo timing as built
  localparam int unsigned SERVO_PERIOD   = PERIOD_US_DEF;
  localparam int unsigned SWEEP_PULSES   = FULL_SWEEP_DEF;
  localparam int          TIMEOUT_CYCLES = 100_000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic               pan_pin;
    logic               tilt_pin;
    logic               busy;
    logic               dropped;
    logic [ANGLE_W-1:0] pan_now;
    logic [ANGLE_W-1:0] tilt_now;
  } servo_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [KIND_W-1:0]    kind_i      = '0;
  logic [COORD_W-1:0]   face_x_i    = '0;
  logic [COORD_W-1:0]   face_y_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 pan_pin_o;
  logic                 tilt_pin_o;
  logic                 busy_res_o;
  logic                 dropped_o;
  logic [ANGLE_W-1:0]   pan_now_o;
  logic [ANGLE_W-1:0]   tilt_now_o;

  // tracker model: configuration and state
  logic [COORD_W-1:0] trk_center_x;
  logic [COORD_W-1:0] trk_center_y;
  logic [DB_W-1:0]    trk_deadband;
  logic [STEP_W-1:0]  trk_step;
  logic [ANGLE_W-1:0] trk_pan;
  logic [ANGLE_W-1:0] trk_tilt;
  logic [PULSE_W-1:0] trk_pan_left;
  logic [PULSE_W-1:0] trk_tilt_left;
  logic [CNT_W-1:0]   trk_count;
  logic [HIGH_W-1:0]  trk_high;
  logic               trk_on_tilt;

  servo_result_t pending_results[$];
  servo_result_t got;
  servo_result_t want;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int drops_seen      = 0;
  int periods_done    = 0;
  int high_ticks      = 0;
  int cycle_count     = 0;

  pan_tilt_deadband_servo_tracker #(
    .PERIOD_US         (SERVO_PERIOD),
    .FULL_SWEEP_PULSES (SWEEP_PULSES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .face_x_i    (face_x_i),
    .face_y_i    (face_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pan_pin_o   (pan_pin_o),
    .tilt_pin_o  (tilt_pin_o),
    .busy_res_o  (busy_res_o),
    .dropped_o   (dropped_o),
    .pan_now_o   (pan_now_o),
    .tilt_now_o  (tilt_now_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             pending_results.size());
    $display("simulation failed");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {pan_pin_o, tilt_pin_o, busy_res_o, dropped_o, pan_now_o, tilt_now_o};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: pins %b/%b busy %b drop %b angles %0d/%0d",
                   cycle_count, got.pan_pin, got.tilt_pin, got.busy, got.dropped,
                   got.pan_now, got.tilt_now);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"mismatch on result %0d: expected pins %b/%b busy %b drop %b ",
                      "angles %0d/%0d, got pins %b/%b busy %b drop %b angles %0d/%0d"},
                     results_checked, want.pan_pin, want.tilt_pin, want.busy,
                     want.dropped, want.pan_now, want.tilt_now, got.pan_pin,
                     got.tilt_pin, got.busy, got.dropped, got.pan_now, got.tilt_now);
        end
      end
    end
  end

  // floor(10.3 * angle + 546) in integer form
  function automatic logic [HIGH_W-1:0] pulse_width(input logic [ANGLE_W-1:0] angle);
    int unsigned w;
    w = (103 * int'(angle) + 5460) / 10;
    return w[HIGH_W-1:0];
  endfunction

  // ceil(|a - b| * 2 / 9)
  function automatic logic [PULSE_W-1:0] pulse_count(input logic [ANGLE_W-1:0] a,
                                                     input logic [ANGLE_W-1:0] b);
    int unsigned d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    d = (d * 2 + 8) / 9;
    return d[PULSE_W-1:0];
  endfunction

  // one axis against the deadband, clamped to 0..180
  task automatic step_axis(inout logic [ANGLE_W-1:0] angle, input logic [COORD_W-1:0] face,
                           input logic [COORD_W-1:0] centre,
                           output logic [PULSE_W-1:0] pulses);
    int f;
    int c;
    int db;
    int a;
    logic [ANGLE_W-1:0] prev;
    f = int'(face);
    c = int'(centre);
    db = int'(trk_deadband);
    a = int'(angle);
    prev = angle;
    pulses = '0;
    if (f > c + db) begin
      a = a + int'(trk_step);
      if (a > 180) a = 180;
    end else if (f < c - db) begin
      a = a - int'(trk_step);
      if (a < 0) a = 0;
    end else begin
      return;
    end
    angle = a[ANGLE_W-1:0];
    pulses = pulse_count(angle, prev);
  endtask

  // advance the tracker by one item and form its result
  task automatic advance_tracker(input logic [KIND_W-1:0] kind,
                                 input logic [COORD_W-1:0] fx,
                                 input logic [COORD_W-1:0] fy,
                                 output servo_result_t res);
    logic busy;
    logic level;
    busy = (trk_pan_left != 0) || (trk_tilt_left != 0);
    res = '0;
    if (kind == KIND_OBSERVE || kind == KIND_ALIGN) begin
      if (busy) begin
        res.dropped = 1'b1;
      end else begin
        if (kind == KIND_OBSERVE) begin
          step_axis(trk_pan, fx, trk_center_x, trk_pan_left);
          step_axis(trk_tilt, fy, trk_center_y, trk_tilt_left);
        end else begin
          trk_pan = ANGLE_CENTER;
          trk_tilt = ANGLE_CENTER;
          trk_pan_left = PULSE_W'(SWEEP_PULSES);
          trk_tilt_left = PULSE_W'(SWEEP_PULSES);
        end
        // start the pulse train, pan first
        trk_count = '0;
        if (trk_pan_left != 0) begin
          trk_on_tilt = 1'b0;
          trk_high = pulse_width(trk_pan);
        end else if (trk_tilt_left != 0) begin
          trk_on_tilt = 1'b1;
          trk_high = pulse_width(trk_tilt);
        end
      end
    end else if (busy) begin
      // tick: drive the active pin, then close the period if due
      level = (trk_count < CNT_W'(trk_high));
      if (level) high_ticks++;
      if (!trk_on_tilt) res.pan_pin = level;
      else res.tilt_pin = level;
      trk_count = trk_count + 1'b1;
      if (trk_count >= CNT_W'(SERVO_PERIOD)) begin
        trk_count = '0;
        periods_done++;
        if (!trk_on_tilt) begin
          if (trk_pan_left != 0) trk_pan_left = trk_pan_left - 1'b1;
          if (trk_pan_left == 0 && trk_tilt_left != 0) begin
            trk_on_tilt = 1'b1;
            trk_high = pulse_width(trk_tilt);
          end
        end else if (trk_tilt_left != 0) begin
          trk_tilt_left = trk_tilt_left - 1'b1;
        end
      end
    end
    res.busy = (trk_pan_left != 0) || (trk_tilt_left != 0);
    res.pan_now = trk_pan;
    res.tilt_now = trk_tilt;
  endtask

  // drive one item, wait for acceptance, queue its expected result
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] fx,
                           input logic [COORD_W-1:0] fy);
    servo_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      kind_i <= KIND_W'($urandom);
      face_x_i <= COORD_W'($urandom);
      face_y_i <= COORD_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    face_x_i <= fx;
    face_y_i <= fy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_tracker(kind, fx, fy, res);
    if (res.dropped) drops_seen++;
    pending_results.push_back(res);
    items_sent++;
  endtask

  function automatic logic [KIND_W-1:0] tick_kind();
    return ($urandom_range(9) == 0) ? KIND_SPARE : KIND_TICK;
  endfunction

  // stop sending and let every pending result come back
  task automatic wait_until_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_CENTER_X: trk_center_x = value[COORD_W-1:0];
      CFG_CENTER_Y: trk_center_y = value[COORD_W-1:0];
      CFG_DEADBAND: trk_deadband = value[DB_W-1:0];
      CFG_STEP:     trk_step = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int cx, input int cy, input int db, input int st);
    wait_until_idle();
    write_reg(CFG_CENTER_X, CFG_W'(cx));
    write_reg(CFG_CENTER_Y, CFG_W'(cy));
    write_reg(CFG_DEADBAND, CFG_W'(db));
    write_reg(CFG_STEP, CFG_W'(st));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // face coordinate biased toward the deadband edges
  function automatic logic [COORD_W-1:0] pick_face(input logic [COORD_W-1:0] centre);
    int v;
    int c;
    int db;
    c = int'(centre);
    db = int'(trk_deadband);
    case ($urandom_range(5))
      0, 1: v = int'($urandom_range(4095));
      2:    v = c + db + int'($urandom_range(1, 300));
      3:    v = c - db - int'($urandom_range(1, 300));
      4:    v = $urandom_range(1) ? c + db + int'($urandom_range(1))
                                  : c - db - int'($urandom_range(1));
      default: v = c;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[COORD_W-1:0];
  endfunction

  // ticks with nothing queued, unused kind included
  task automatic test_idle_ticks();
    send_item(KIND_TICK, '0, '0);
    send_item(KIND_SPARE, 12'hFFF, 12'hFFF);
    send_item(KIND_TICK, 12'hAAA, 12'h555);
  endtask

  // faces inside and on the deadband at reset settings, nothing moves
  task automatic test_deadband();
    send_item(KIND_OBSERVE, 12'd640, 12'd360);
    send_item(KIND_OBSERVE, 12'd660, 12'd340);
    send_item(KIND_OBSERVE, 12'd620, 12'd380);
    send_item(KIND_OBSERVE, 12'd660, 12'd380);
    send_item(KIND_OBSERVE, 12'd620, 12'd340);
  endtask

  task automatic test_zero_step();
    set_config(640, 360, 20, 0);
    send_item(KIND_OBSERVE, 12'hFFF, '0);
    send_item(KIND_OBSERVE, '0, 12'hFFF);
  endtask

  // a move just past the deadband starts a pulse train, commands are then dropped
  task automatic test_busy_drop();
    set_config(640, 360, 20, 45);
    send_item(KIND_OBSERVE, 12'd619, 12'd381);
    send_item(KIND_OBSERVE, '0, '0);
    send_item(KIND_ALIGN, '0, '0);
    send_item(KIND_SPARE, '0, '0);
    send_item(KIND_TICK, '0, '0);
    send_item(KIND_OBSERVE, 12'hFFF, 12'hFFF);
  endtask

  // ticks until the pan pin has fallen at the end of its high time
  task automatic test_pulse_edge();
    while ((trk_pan_left != 0 || trk_tilt_left != 0) && !trk_on_tilt &&
           int'(trk_count) <= int'(trk_high) + 3)
      send_item(tick_kind(), COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // mixed random traffic under one idle/stall setting; hold_still keeps the angles put
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int budget,
                                     input bit hold_still);
    int sent;
    int pick;
    int len;
    int step;
    step = hold_still ? 0 : int'($urandom_range(1, 8));
    set_config($urandom_range(4095), $urandom_range(4095), $urandom_range(255), step);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_item(KIND_OBSERVE, pick_face(trk_center_x), pick_face(trk_center_y));
        sent++;
      end else if (pick < 50 && !hold_still) begin
        send_item(KIND_ALIGN, COORD_W'($urandom), COORD_W'($urandom));
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) send_item(tick_kind(), COORD_W'($urandom), COORD_W'($urandom));
        sent += len;
      end
    end
    wait_until_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    // model starts from the reset state
    trk_center_x = CENTER_X_RST;
    trk_center_y = CENTER_Y_RST;
    trk_deadband = DEADBAND_RST;
    trk_step = STEP_RST;
    trk_pan = ANGLE_CENTER;
    trk_tilt = ANGLE_CENTER;
    trk_pan_left = '0;
    trk_tilt_left = '0;
    trk_count = '0;
    trk_high = '0;
    trk_on_tilt = 1'b0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_ticks();
    test_deadband();
    test_zero_step();
    test_random_traffic(38, 80, 300, 1'b1);
    test_busy_drop();
    test_random_traffic(80, 38, 300, 1'b0);
    test_random_traffic(0, 0, 300, 1'b0);
    test_pulse_edge();

    wait_until_idle();
    $display("tracker run: %0d items sent, %0d results checked, %0d errors", items_sent,
             results_checked, errors);
    $display("dropped while busy: %0d, pin high ticks: %0d, servo periods completed: %0d",
             drops_seen, high_ticks, periods_done);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
